// ----- rtl/lfu_cache_table_defines.svh -----
// lfu_cache_table_defines.svh: assertion macros for the lfu cache table checker
// needs clk and arst_n in the scope where a macro is used
`ifndef LFU_CACHE_TABLE_DEFINES_SVH
`define LFU_CACHE_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LFU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfu check failed: same-cycle rule");

// next-cycle implication, sampled on clk, off during reset
`define LFU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfu check failed: next-cycle rule");

`endif

// ----- rtl/lfu_pkg.sv -----
// lfu_pkg: shared widths, codes and types for the lfu cache table
// no dependencies
package lfu_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// action codes
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// status of one scan pass
	typedef struct packed {
		logic found;      // a valid entry holds the key
		logic vic_found;  // at least one valid entry exists
		logic free_found; // at least one empty slot exists
	} scan_flags_t;

endpackage

// ----- rtl/lfu_row_mem.sv -----
// lfu_row_mem: one-write one-read memory with registered read data
// holds key, value and use count of each entry; no dependencies
module lfu_row_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 80
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/lfu_scan.sv -----
// lfu_scan: shared compare unit stepped once per entry during a scan pass
// finds the key, the eviction victim, the first free slot and the fill; uses lfu_pkg
module lfu_scan import lfu_pkg::*; #(
	parameter int IW     = 4,
	parameter int CNT_W  = 16,
	parameter int USED_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear,
	input  logic              step,
	input  logic [IW-1:0]     step_idx,
	input  logic              step_valid,
	input  logic [IW-1:0]     step_rank,
	input  logic [DATA_W-1:0] step_key,
	input  logic [DATA_W-1:0] step_value,
	input  logic [CNT_W-1:0]  step_count,
	input  logic [DATA_W-1:0] key,
	output scan_flags_t       flags,
	output logic [IW-1:0]     hit_idx,
	output logic [DATA_W-1:0] hit_value,
	output logic [CNT_W-1:0]  hit_count,
	output logic [IW-1:0]     hit_rank,
	output logic [IW-1:0]     vic_idx,
	output logic [IW-1:0]     vic_rank,
	output logic [IW-1:0]     free_idx,
	output logic [USED_W-1:0] used
);

	scan_flags_t       flags_q;
	logic [IW-1:0]     hit_idx_q;
	logic [DATA_W-1:0] hit_value_q;
	logic [CNT_W-1:0]  hit_count_q;
	logic [IW-1:0]     hit_rank_q;
	logic [IW-1:0]     vic_idx_q;
	logic [CNT_W-1:0]  vic_count_q;
	logic [IW-1:0]     vic_rank_q;
	logic [IW-1:0]     free_idx_q;
	logic [USED_W-1:0] used_q;
	logic              take_hit;
	logic              take_vic;
	logic              take_free;

	// compare of the current entry against the key and the running victim
	always_comb begin
		take_hit  = step && step_valid && !flags_q.found && (step_key == key);
		take_vic  = step && step_valid &&
			(!flags_q.vic_found || (step_count < vic_count_q) ||
			 ((step_count == vic_count_q) && (step_rank > vic_rank_q)));
		take_free = step && !step_valid && !flags_q.free_found;
	end

	// control flags and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			used_q  <= '0;
		end else if (clear) begin
			flags_q <= '0;
			used_q  <= '0;
		end else begin
			if (take_hit) flags_q.found <= 1'b1;
			if (take_vic) flags_q.vic_found <= 1'b1;
			if (take_free) flags_q.free_found <= 1'b1;
			if (step && step_valid) used_q <= used_q + 1'b1;
		end
	end

	// captured entry data
	always_ff @(posedge clk) begin
		if (take_hit) begin
			hit_idx_q   <= step_idx;
			hit_value_q <= step_value;
			hit_count_q <= step_count;
			hit_rank_q  <= step_rank;
		end
		if (take_vic) begin
			vic_idx_q   <= step_idx;
			vic_count_q <= step_count;
			vic_rank_q  <= step_rank;
		end
		if (take_free) begin
			free_idx_q <= step_idx;
		end
	end

	assign flags     = flags_q;
	assign hit_idx   = hit_idx_q;
	assign hit_value = hit_value_q;
	assign hit_count = hit_count_q;
	assign hit_rank  = hit_rank_q;
	assign vic_idx   = vic_idx_q;
	assign vic_rank  = vic_rank_q;
	assign free_idx  = free_idx_q;
	assign used      = used_q;

endmodule

// ----- rtl/lfu_cache_table.sv -----
// lfu_cache_table: fully associative key/value store, lfu replacement with lru tiebreak
// uses lfu_pkg, lfu_row_mem and lfu_scan
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------
//   input    | in_valid / in_ready       | action, key, value
//   output   | out_valid / out_ready     | hit, read_value (lookups only)
//   config   | cfg_wr_en                 | cfg_wr_data (capacity)
//
// each item scans every entry, reading one row of the entry memory per cycle through
// its single read port; a store ends after ST_DECIDE, a lookup after ST_RESP.
// in_ready is high only while idle; a finished result sits in the output register
// and the next item is taken while it waits. a result held by out_ready low
// stalls the block only when the next lookup needs the output register.
// arst_n clears valid bits, capacity (to 16) and control; no clearing pass.
module lfu_cache_table import lfu_pkg::*; #(
	parameter int ENTRIES     = 16,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     action,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_value,
	input  logic                     cfg_wr_en,
	input  logic [CAP_W-1:0]         cfg_wr_data
);

	localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int UW    = (CW > CAP_W) ? CW : CAP_W;
	localparam int ROW_W = 2 * DATA_W + COUNT_WIDTH;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_RESP   = 2'd3;

	logic [1:0]             state_q;
	logic [CAP_W-1:0]       capacity_q;
	logic                   act_q;
	logic [DATA_W-1:0]      key_q;
	logic [DATA_W-1:0]      val_q;
	logic [CW-1:0]          cnt_q;
	logic                   step_s1;
	logic [IW-1:0]          idx_s1;
	logic                   valid_q [ENTRIES];
	logic [IW-1:0]          rank_q  [ENTRIES];
	logic                   out_valid_q;
	logic                   hit_q;
	logic [DATA_W-1:0]      read_value_q;

	logic                   accept;
	logic                   issue;
	logic                   scan_last;
	logic [IW-1:0]          rd_addr;
	logic [ROW_W-1:0]       rd_row;
	scan_flags_t            flags;
	logic [IW-1:0]          hit_idx;
	logic [DATA_W-1:0]      hit_value;
	logic [COUNT_WIDTH-1:0] hit_count;
	logic [IW-1:0]          hit_rank;
	logic [IW-1:0]          vic_idx;
	logic [IW-1:0]          vic_rank;
	logic [IW-1:0]          free_idx;
	logic [CW-1:0]          used;
	logic [UW-1:0]          cap_ext;
	logic [UW-1:0]          cap_eff;
	logic [COUNT_WIDTH-1:0] sat_count;
	logic                   do_write;
	logic                   set_valid;
	logic [IW-1:0]          wr_slot;
	logic [IW-1:0]          r_ref;
	logic [ROW_W-1:0]       wr_row;
	logic                   out_load;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign issue     = (state_q == ST_SCAN) && (cnt_q < CW'(ENTRIES));
	assign rd_addr   = issue ? cnt_q[IW-1:0] : '0;
	assign scan_last = step_s1 && (idx_s1 == IW'(ENTRIES - 1));
	assign out_load  = (state_q == ST_RESP) && (!out_valid_q || out_ready);

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			capacity_q <= cfg_wr_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			step_s1 <= 1'b0;
		end else begin
			step_s1 <= issue;
			if (issue) cnt_q <= cnt_q + 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_last) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= (act_q == ACT_GET) ? ST_RESP : ST_IDLE;
				end
				ST_RESP: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture and scan index pipeline
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= key;
			val_q <= value;
		end
		idx_s1 <= cnt_q[IW-1:0];
	end

	// entry memory
	lfu_row_mem #(
		.DEPTH(ENTRIES),
		.WIDTH(ROW_W)
	) u_mem (
		.clk  (clk),
		.we   (do_write),
		.waddr(wr_slot),
		.wdata(wr_row),
		.raddr(rd_addr),
		.rdata(rd_row)
	);

	// shared compare unit
	lfu_scan #(
		.IW    (IW),
		.CNT_W (COUNT_WIDTH),
		.USED_W(CW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.step      (step_s1),
		.step_idx  (idx_s1),
		.step_valid(valid_q[idx_s1]),
		.step_rank (rank_q[idx_s1]),
		.step_key  (rd_row[ROW_W-1 -: DATA_W]),
		.step_value(rd_row[COUNT_WIDTH +: DATA_W]),
		.step_count(rd_row[COUNT_WIDTH-1:0]),
		.key       (key_q),
		.flags     (flags),
		.hit_idx   (hit_idx),
		.hit_value (hit_value),
		.hit_count (hit_count),
		.hit_rank  (hit_rank),
		.vic_idx   (vic_idx),
		.vic_rank  (vic_rank),
		.free_idx  (free_idx),
		.used      (used)
	);

	// decide the write-back after the scan
	always_comb begin
		cap_ext   = UW'(capacity_q);
		cap_eff   = (cap_ext > UW'(ENTRIES)) ? UW'(ENTRIES) : cap_ext;
		sat_count = (hit_count == '1) ? hit_count : hit_count + 1'b1;
		do_write  = 1'b0;
		set_valid = 1'b0;
		wr_slot   = hit_idx;
		r_ref     = hit_rank;
		wr_row    = {key_q, hit_value, sat_count};
		if (state_q == ST_DECIDE) begin
			if (act_q == ACT_GET) begin
				do_write = flags.found;
			end else if (cap_eff != '0) begin
				if (flags.found) begin
					do_write = 1'b1;
					wr_row   = {key_q, val_q, sat_count};
				end else if ((UW'(used) >= cap_eff) && flags.vic_found) begin
					do_write  = 1'b1;
					set_valid = 1'b1;
					wr_slot   = vic_idx;
					r_ref     = vic_rank;
					wr_row    = {key_q, val_q, COUNT_WIDTH'(1)};
				end else if (flags.free_found) begin
					do_write  = 1'b1;
					set_valid = 1'b1;
					wr_slot   = free_idx;
					r_ref     = used[IW-1:0];
					wr_row    = {key_q, val_q, COUNT_WIDTH'(1)};
				end
			end
		end
	end

	// valid bits and recency ranks, touched entry moves to most recent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ENTRIES; j++) begin
				valid_q[j] <= 1'b0;
			end
		end else if (do_write && set_valid) begin
			valid_q[wr_slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (IW'(j) == wr_slot) begin
					rank_q[j] <= '0;
				end else if (valid_q[j] && (rank_q[j] < r_ref)) begin
					rank_q[j] <= rank_q[j] + 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q        <= flags.found;
			read_value_q <= flags.found ? hit_value : MISS_VALUE;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule

// ----- rtl/lfu_cache_table_check.sv -----
// lfu_cache_table_check: port-level checks on lfu_cache_table, bound to the top level
// uses lfu_pkg and lfu_cache_table_defines.svh
`include "lfu_cache_table_defines.svh"

module lfu_cache_table_check import lfu_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     action,
	input logic signed [DATA_W-1:0] key,
	input logic signed [DATA_W-1:0] value,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic                     hit,
	input logic signed [DATA_W-1:0] read_value,
	input logic                     cfg_wr_en,
	input logic [CAP_W-1:0]         cfg_wr_data
);

	// a stalled result holds
	`LFU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(read_value))

	// a miss always reads as all ones
	`LFU_ASSERT_NOW(a_miss_value, out_valid && !hit, read_value == MISS_VALUE)

	// one item at a time: ready drops after an accepted item
	`LFU_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// no result appears right after an item is taken
	`LFU_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid))

endmodule

bind lfu_cache_table lfu_cache_table_check u_check (.*);
